// File: rtl/label_overlap_histogram_top_assert.svh
// ----------------------------------------------------------------------------
// Label overlap histogram assertion macros
// Short forms for clocked implication checks, reset masked.
// ----------------------------------------------------------------------------
`ifndef LABEL_OVERLAP_HISTOGRAM_TOP_ASSERT_SVH
`define LABEL_OVERLAP_HISTOGRAM_TOP_ASSERT_SVH

// Same-cycle implication.
`define LOH_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define LOH_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/loh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label overlap histogram package
// Shared widths, codes, control structs and helper functions.
// ----------------------------------------------------------------------------
package loh_pkg;

   localparam int LABEL_W     = 8;
   localparam int LABEL_COUNT = 2 ** LABEL_W;
   localparam int COUNT_W     = 32;
   localparam int PCT_W       = 14;
   localparam int PCT_FULL    = 10000;
   localparam int PROD_W      = COUNT_W + PCT_W;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   typedef logic [LABEL_W-1:0] label_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [PROD_W-1:0]  prod_type;
   typedef logic [PCT_W-1:0]   pct_type;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_VOXEL = 2'd1,
      ACT_LABEL = 2'd2,
      ACT_TOTAL = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_MISSING = 2'd1,
      STS_CLEARED = 2'd2
   } status_type;

   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_MULTI_MODE = 2'd0;
   localparam reg_index_type REG_REF_SEL    = 2'd1;
   localparam reg_index_type REG_IN_SEL     = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SWEEP,
      ST_SWEEP_END,
      ST_CHECK,
      ST_DIV_REF_GO,
      ST_DIV_REF_WAIT,
      ST_DIV_IN_GO,
      ST_DIV_IN_WAIT
   } state_type;

   typedef struct packed {
      logic      upd;
      label_type upd_ref;
      label_type upd_in;
      logic      upd_hit;
      logic      clear;
      label_type rd_ref;
      label_type rd_in;
   } hist_cmd_type;

   typedef struct packed {
      count_type ref_cnt;
      count_type ovl_cnt;
      count_type in_cnt;
   } hist_data_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == '1) ? v : v + count_type'(1);
   endfunction

   function automatic count_type sat_add(input count_type a, input count_type b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
   endfunction

   function automatic pct_type pct_clamp(input prod_type q);
      return (q > prod_type'(PCT_FULL)) ? pct_type'(PCT_FULL) : q[PCT_W-1:0];
   endfunction

endpackage

// File: rtl/loh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label overlap histogram RAM
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module loh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/loh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label overlap histogram divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module loh_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  loh_pkg::prod_type dividend,
   input  loh_pkg::count_type divisor,
   output logic              done,
   output loh_pkg::prod_type quotient
);
   import loh_pkg::*;

   localparam int CNT_W = $clog2(PROD_W + 1);

   count_type          rem_ff, rem_in;
   prod_type           quo_ff, quo_in;
   count_type          dsr_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W+1:0] diff;
   logic               ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[PROD_W-1]};
      diff   = {1'b0, trial} - {2'b00, dsr_ff};
      ge     = !diff[COUNT_W+1];
      rem_in = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quo_in = {quo_ff[PROD_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
         cnt_ff <= CNT_W'(PROD_W);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/loh_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label overlap histogram tables
// Reference/overlap and input count memories with read-modify-write update.
// ----------------------------------------------------------------------------
module loh_hist (
   input  logic                   clock,
   input  logic                   reset,
   input  loh_pkg::hist_cmd_type  cmd,
   output loh_pkg::hist_data_type data,
   output logic                   busy,
   output logic                   clearing
);
   import loh_pkg::*;

   localparam int PAIR_W = 2 * COUNT_W;

   label_type               a_addr, b_addr;
   label_type               ra_addr_ff, rb_addr_ff;
   logic                    s1_valid_ff, s1_hit_ff;
   logic                    clr_busy_ff;
   label_type               clr_addr_ff;
   logic                    fa_valid_ff, fb_valid_ff;
   label_type               fa_addr_ff, fb_addr_ff;
   logic [PAIR_W-1:0]       fa_data_ff;
   count_type               fb_data_ff;
   logic [PAIR_W-1:0]       a_rdata, a_cur, a_wdata;
   count_type               b_rdata, b_cur, b_wdata;
   logic                    a_we, b_we;
   logic                    a_wr_en, b_wr_en;
   label_type               a_wr_addr, b_wr_addr;
   logic [PAIR_W-1:0]       a_wr_data;
   count_type               b_wr_data;

   assign a_addr = cmd.upd ? cmd.upd_ref : cmd.rd_ref;
   assign b_addr = cmd.upd ? cmd.upd_in  : cmd.rd_in;

   // the clearing pass owns the write ports while it runs
   assign a_wr_en   = clr_busy_ff || a_we;
   assign b_wr_en   = clr_busy_ff || b_we;
   assign a_wr_addr = clr_busy_ff ? clr_addr_ff : ra_addr_ff;
   assign b_wr_addr = clr_busy_ff ? clr_addr_ff : rb_addr_ff;
   assign a_wr_data = clr_busy_ff ? '0 : a_wdata;
   assign b_wr_data = clr_busy_ff ? '0 : b_wdata;

   loh_ram #(.WIDTH(PAIR_W), .DEPTH(LABEL_COUNT)) u_ref_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_addr (a_addr),
      .rd_data (a_rdata)
   );

   loh_ram #(.WIDTH(COUNT_W), .DEPTH(LABEL_COUNT)) u_in_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data),
      .rd_addr (b_addr),
      .rd_data (b_rdata)
   );

   // take the word written last cycle, else the memory
   always_comb begin
      a_cur = (fa_valid_ff && fa_addr_ff == ra_addr_ff) ? fa_data_ff : a_rdata;
      b_cur = (fb_valid_ff && fb_addr_ff == rb_addr_ff) ? fb_data_ff : b_rdata;
      a_we  = s1_valid_ff && (ra_addr_ff != '0);
      b_we  = s1_valid_ff && (rb_addr_ff != '0);
      a_wdata = {s1_hit_ff ? sat_inc(a_cur[PAIR_W-1:COUNT_W]) : a_cur[PAIR_W-1:COUNT_W],
                 sat_inc(a_cur[COUNT_W-1:0])};
      b_wdata = sat_inc(b_cur);
   end

   // zero every entry after reset and on a clear, one entry per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fa_valid_ff <= 1'b0;
         fb_valid_ff <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         s1_valid_ff <= cmd.upd;
         fa_valid_ff <= a_we;
         fb_valid_ff <= b_we;
         if (cmd.clear) begin
            clr_busy_ff <= 1'b1;
            clr_addr_ff <= '0;
         end else if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + label_type'(1);
            if (clr_addr_ff == label_type'(LABEL_COUNT - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ra_addr_ff <= a_addr;
      rb_addr_ff <= b_addr;
      s1_hit_ff  <= cmd.upd_hit;
      fa_addr_ff <= ra_addr_ff;
      fb_addr_ff <= rb_addr_ff;
      fa_data_ff <= a_wdata;
      fb_data_ff <= b_wdata;
   end

   assign data.ref_cnt = a_cur[COUNT_W-1:0];
   assign data.ovl_cnt = a_cur[PAIR_W-1:COUNT_W];
   assign data.in_cnt  = b_cur;
   assign busy         = s1_valid_ff;
   assign clearing     = clr_busy_ff;

endmodule

// File: rtl/label_overlap_histogram_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label overlap histogram top level
// Per-label voxel counts of two label volumes and their overlap, with reports.
// ----------------------------------------------------------------------------
// Voxel pair words are counted one per cycle while no report or clearing pass
// runs: each word is a read-modify-write of two 256-entry count memories
// (reference plus overlap, and input), with the word written in the previous
// cycle forwarded past the registered read. A clear word is answered at once,
// then a clearing pass writes zero to one entry per cycle, during which no word
// is accepted; the same pass runs after reset before the first word. A label
// report takes one read, one multiply and two passes of the shared restoring
// divider for the two percentages. A total report in multi mode sweeps labels
// 1 to 255 through the memory read port, one per cycle; when a label is
// missing the divider passes are skipped. Report, clear and total words wait
// until the update pipeline has drained and the result register is free;
// voxel words keep flowing while a result waits to be taken.
// ----------------------------------------------------------------------------
module label_overlap_histogram_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic [7:0]                      req_ref_value,
   input  logic [7:0]                      req_in_value,
   input  logic [7:0]                      req_query_label,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [31:0]                     rsp_ref_count,
   output logic [31:0]                     rsp_in_count,
   output logic [31:0]                     rsp_overlap_count,
   output logic [13:0]                     rsp_overlap_of_ref,
   output logic [13:0]                     rsp_overlap_of_in,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [loh_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [loh_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [loh_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import loh_pkg::*;

   `include "label_overlap_histogram_top_assert.svh"

   state_type     state_ff, state_in;
   logic          multi_ff;
   label_type     ref_sel_ff, in_sel_ff;
   label_type     lbl_ff;
   logic          sweep_dv_ff;
   count_type     rsum_ff, isum_ff, osum_ff;
   logic          any_ff, miss_ff;
   prod_type      prod_ff;
   pct_type       pct_r_ff;
   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   count_type     rsp_ref_ff, rsp_in_ff, rsp_ovl_ff;
   pct_type       rsp_pr_ff, rsp_pi_ff;

   action_type    act;
   logic          req_fire;
   logic          csr_wr;
   reg_index_type csr_idx;
   label_type     rl, il;
   hist_cmd_type  cmd;
   hist_data_type hdata;
   logic          hist_busy;
   logic          hist_clearing;
   logic          ok;
   logic          emit_clear, emit_fail, emit_done;
   logic          div_start, div_done;
   count_type     div_dsr;
   prod_type      div_quo;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         multi_ff   <= 1'b1;
         ref_sel_ff <= label_type'(1);
         in_sel_ff  <= label_type'(1);
      end else if (csr_wr) begin
         case (csr_idx)
            REG_MULTI_MODE: multi_ff   <= csr_pwdata[0];
            REG_REF_SEL:    ref_sel_ff <= csr_pwdata[LABEL_W-1:0];
            REG_IN_SEL:     in_sel_ff  <= csr_pwdata[LABEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MULTI_MODE: csr_prdata = CSR_DATA_W'(multi_ff);
         REG_REF_SEL:    csr_prdata = CSR_DATA_W'(ref_sel_ff);
         REG_IN_SEL:     csr_prdata = CSR_DATA_W'(in_sel_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------ input side
   // hold every word while the clearing pass runs or a report is under way;
   // voxel words go straight in otherwise; anything else waits for a drained
   // pipeline and a free result register
   assign act       = action_type'(req_action);
   assign req_ready = (state_ff == ST_IDLE) && !hist_clearing
                      && (act == ACT_VOXEL || (!hist_busy && !rsp_valid_ff));
   assign req_fire  = req_valid && req_ready;

   // in single mode the configured pair stands in for the query
   assign rl = multi_ff ? req_query_label : ref_sel_ff;
   assign il = multi_ff ? req_query_label : in_sel_ff;

   always_comb begin
      cmd.upd     = req_fire && act == ACT_VOXEL;
      cmd.upd_ref = req_ref_value;
      cmd.upd_in  = req_in_value;
      cmd.upd_hit = multi_ff ? (req_ref_value == req_in_value)
                             : (req_ref_value == ref_sel_ff && req_in_value == in_sel_ff);
      cmd.clear   = req_fire && act == ACT_CLEAR;
      cmd.rd_ref  = (state_ff == ST_SWEEP) ? lbl_ff : rl;
      cmd.rd_in   = (state_ff == ST_SWEEP) ? lbl_ff : il;
   end

   loh_hist u_hist (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .data     (hdata),
      .busy     (hist_busy),
      .clearing (hist_clearing)
   );

   // --------------------------------------------------------- report control
   assign ok = any_ff && !miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      emit_clear = 1'b0;
      emit_fail  = 1'b0;
      emit_done  = 1'b0;
      div_start  = 1'b0;
      div_dsr    = rsum_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (act)
                  ACT_CLEAR: emit_clear = 1'b1;
                  ACT_LABEL: state_in = ST_READ;
                  ACT_TOTAL: state_in = multi_ff ? ST_SWEEP : ST_READ;
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_SWEEP: begin
            if (lbl_ff == label_type'(LABEL_COUNT - 1)) begin
               state_in = ST_SWEEP_END;
            end
         end
         ST_SWEEP_END: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (ok) begin
               state_in = ST_DIV_REF_GO;
            end else begin
               emit_fail = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_DIV_REF_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_REF_WAIT;
         end
         ST_DIV_REF_WAIT: begin
            if (div_done) begin
               state_in = ST_DIV_IN_GO;
            end
         end
         ST_DIV_IN_GO: begin
            div_start = 1'b1;
            div_dsr   = isum_ff;
            state_in  = ST_DIV_IN_WAIT;
         end
         ST_DIV_IN_WAIT: begin
            if (div_done) begin
               emit_done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sweep counter and running sums; a single read fills the sums directly
   always_ff @(posedge clock) begin
      sweep_dv_ff <= (state_ff == ST_SWEEP);
      if (state_ff == ST_IDLE) begin
         lbl_ff  <= label_type'(1);
         rsum_ff <= '0;
         isum_ff <= '0;
         osum_ff <= '0;
         any_ff  <= 1'b0;
         miss_ff <= 1'b0;
      end else if (state_ff == ST_READ) begin
         rsum_ff <= hdata.ref_cnt;
         isum_ff <= hdata.in_cnt;
         osum_ff <= hdata.ovl_cnt;
         any_ff  <= hdata.ref_cnt != '0;
         miss_ff <= hdata.in_cnt == '0;
      end else begin
         if (state_ff == ST_SWEEP) begin
            lbl_ff <= lbl_ff + label_type'(1);
         end
         // drop labels absent from the reference
         if (sweep_dv_ff && hdata.ref_cnt != '0) begin
            rsum_ff <= sat_add(rsum_ff, hdata.ref_cnt);
            isum_ff <= sat_add(isum_ff, hdata.in_cnt);
            osum_ff <= sat_add(osum_ff, hdata.ovl_cnt);
            any_ff  <= 1'b1;
            if (hdata.in_cnt == '0) begin
               miss_ff <= 1'b1;
            end
         end
      end
      if (state_ff == ST_CHECK) begin
         prod_ff <= prod_type'(osum_ff) * prod_type'(PCT_FULL);
      end
      if (state_ff == ST_DIV_REF_WAIT && div_done) begin
         pct_r_ff <= pct_clamp(div_quo);
      end
   end

   loh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ------------------------------------------------------------ result side
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_clear || emit_fail || emit_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_clear) begin
         rsp_status_ff <= STS_CLEARED;
         rsp_ref_ff    <= '0;
         rsp_in_ff     <= '0;
         rsp_ovl_ff    <= '0;
         rsp_pr_ff     <= '0;
         rsp_pi_ff     <= '0;
      end else if (emit_fail || emit_done) begin
         rsp_status_ff <= emit_done ? STS_OK : STS_MISSING;
         rsp_ref_ff    <= rsum_ff;
         rsp_in_ff     <= isum_ff;
         rsp_ovl_ff    <= osum_ff;
         rsp_pr_ff     <= emit_done ? pct_r_ff : '0;
         rsp_pi_ff     <= emit_done ? pct_clamp(div_quo) : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_ref_count      = rsp_ref_ff;
   assign rsp_in_count       = rsp_in_ff;
   assign rsp_overlap_count  = rsp_ovl_ff;
   assign rsp_overlap_of_ref = rsp_pr_ff;
   assign rsp_overlap_of_in  = rsp_pi_ff;

   // ------------------------------------------------------------- assertions
   `LOH_ASSERT_NEXT(a_report_leaves_idle, req_fire && act != ACT_VOXEL, state_ff != ST_IDLE || rsp_valid_ff, "report word neither started nor answered")
   `LOH_ASSERT_NOW(a_div_done_when_waiting, div_done, state_ff == ST_DIV_REF_WAIT || state_ff == ST_DIV_IN_WAIT, "divider finished outside a wait state")
   `LOH_ASSERT_NOW(a_divisors_nonzero, state_ff == ST_CHECK && ok, rsum_ff != '0 && isum_ff != '0, "percentage taken of a zero volume")
   `LOH_ASSERT_NOW(a_no_update_in_report, state_ff != ST_IDLE, !cmd.upd, "voxel update during a report")
   `LOH_ASSERT_NOW(a_no_update_in_clear, hist_clearing, !cmd.upd, "voxel update during the clearing pass")

endmodule
